// File: hw/rtl/tnorm_pkg.sv
// Shared types, constants and symbol functions of the transcript text normaliser.
package tnorm_pkg;

  localparam int APOS_MAX = 16;
  localparam int HELD_CAP = (APOS_MAX < 17) ? APOS_MAX : 17;
  localparam int WORD_SLOTS = 3;

  localparam logic [7:0] PFX_LEAD  = 8'hE2;
  localparam logic [7:0] PFX_MID   = 8'h80;
  localparam logic [7:0] QUOTE_L   = 8'h98;
  localparam logic [7:0] QUOTE_R   = 8'h99;
  localparam logic [7:0] DASH_EN   = 8'h93;
  localparam logic [7:0] DASH_EM   = 8'h94;
  localparam logic [7:0] DQUOTE_L  = 8'h9C;
  localparam logic [7:0] DQUOTE_R  = 8'h9D;
  localparam logic [7:0] ELLIPSIS  = 8'hA6;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CASE_STEP  = 8'h20;
  localparam logic [7:0] HIGH_BASE  = 8'h80;

  localparam logic [4:0] HELD_LIMIT = 5'(HELD_CAP);

  typedef enum logic [2:0] {
    PST_NONE = 3'b001,
    PST_E2   = 3'b010,
    PST_E280 = 3'b100
  } pst_t;

  // one request's worth of results
  typedef struct packed {
    logic [7:0]                  lead_byte;
    logic [4:0]                  lead_cnt;
    logic [WORD_SLOTS-1:0][7:0]  w;
    logic [1:0]                  nw;
    logic                        text_last;
    logic                        marker;
  } plan_t;

  typedef struct packed {
    logic  valid;
    plan_t plan;
  } req_t;

  typedef struct packed {
    pst_t       pst;
    logic       word_open;
    logic [4:0] held;
    logic       emitted;
    plan_t      plan;
  } ctx_t;

  function automatic ctx_t f_word(ctx_t c, logic [7:0] b);
    ctx_t r;
    r = c;
    if (!r.word_open) begin
      if (r.emitted) begin
        r.plan.lead_byte = CH_SPACE;
        r.plan.lead_cnt  = 5'd1;
      end
      r.word_open = 1'b1;
      r.emitted   = 1'b1;
    end else if (r.held != 5'd0) begin
      r.plan.lead_byte = CH_APOS;
      r.plan.lead_cnt  = r.held;
    end
    r.held = 5'd0;
    if (r.plan.nw < 2'(WORD_SLOTS)) begin
      r.plan.w[r.plan.nw] = b;
      r.plan.nw = r.plan.nw + 2'd1;
    end
    return r;
  endfunction

  function automatic ctx_t f_apos(ctx_t c);
    ctx_t r;
    r = c;
    if (r.word_open && (r.held < HELD_LIMIT)) begin
      r.held = r.held + 5'd1;
    end
    return r;
  endfunction

  function automatic ctx_t f_sep(ctx_t c);
    ctx_t r;
    r = c;
    r.word_open = 1'b0;
    r.held      = 5'd0;
    return r;
  endfunction

  function automatic ctx_t f_plain(ctx_t c, logic [7:0] b);
    ctx_t r;
    r = c;
    if (b == PFX_LEAD) begin
      r.pst = PST_E2;
    end else if (b >= HIGH_BASE || (b >= CH_LOWER_A && b <= CH_LOWER_Z) ||
                 (b >= CH_DIGIT_0 && b <= CH_DIGIT_9)) begin
      r = f_word(r, b);
    end else if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = f_word(r, b + CASE_STEP);
    end else if (b == CH_APOS) begin
      r = f_apos(r);
    end else begin
      r = f_sep(r);
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/transcript_text_normalizer.sv
// Top level of the transcript text normaliser.
//
//  channel | direction | handshake            | payload
//  in      | receive   | in_valid / in_stall  | in_byte, in_last
//  out     | send      | out_valid / out_stall| out_byte, byte_present, text_end, run_end
//
// A request is held in the input register, then its results leave the sequencer
// one per cycle while the output does not stall; a request with several results keeps
// the sequencer busy and stalls the next request until its last result is taken.
// A request causing no result passes without waiting for the sequencer; a byte opening a word after an
// earlier word gives two results, other plain text flows one byte a cycle unless the output stalls.
// Reset clears the word state and both stages; no clearing pass.
// Stall on the output holds the current result and backs up into the input.
module transcript_text_normalizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_present,
  output logic       text_end,
  output logic       run_end
);

  tnorm_pkg::req_t req;
  logic            emit_free;

  tnorm_plan u_plan (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .emit_free(emit_free),
    .req      (req)
  );

  tnorm_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .emit_free   (emit_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .byte_present(byte_present),
    .text_end    (text_end),
    .run_end     (run_end)
  );

endmodule

// File: hw/rtl/tnorm_plan.sv
// Input register, word state and per-request result planning.
module tnorm_plan (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  input  logic                emit_free,
  output tnorm_pkg::req_t     req
);

  logic                in_full;
  logic [7:0]          byte_r;
  logic                last_r;
  tnorm_pkg::pst_t     pst;
  logic                word_open;
  logic [4:0]          held;
  logic                emitted;
  tnorm_pkg::ctx_t     ctx;
  logic                has;
  logic                take;
  logic                accept;

  always_comb begin
    ctx = '0;
    ctx.pst       = pst;
    ctx.word_open = word_open;
    ctx.held      = held;
    ctx.emitted   = emitted;
    ctx.plan.text_last = last_r;
    unique case (pst)
      tnorm_pkg::PST_E2: begin
        if (byte_r == tnorm_pkg::PFX_MID) begin
          ctx.pst = tnorm_pkg::PST_E280;
        end else begin
          ctx.pst = tnorm_pkg::PST_NONE;
          ctx = tnorm_pkg::f_word(ctx, tnorm_pkg::PFX_LEAD);
          ctx = tnorm_pkg::f_plain(ctx, byte_r);
        end
      end
      tnorm_pkg::PST_E280: begin
        ctx.pst = tnorm_pkg::PST_NONE;
        if (byte_r == tnorm_pkg::QUOTE_L || byte_r == tnorm_pkg::QUOTE_R) begin
          ctx = tnorm_pkg::f_apos(ctx);
        end else if (byte_r == tnorm_pkg::DASH_EN || byte_r == tnorm_pkg::DASH_EM ||
                     byte_r == tnorm_pkg::DQUOTE_L || byte_r == tnorm_pkg::DQUOTE_R ||
                     byte_r == tnorm_pkg::ELLIPSIS) begin
          ctx = tnorm_pkg::f_sep(ctx);
        end else begin
          ctx = tnorm_pkg::f_word(ctx, tnorm_pkg::PFX_LEAD);
          ctx = tnorm_pkg::f_word(ctx, tnorm_pkg::PFX_MID);
          ctx = tnorm_pkg::f_plain(ctx, byte_r);
        end
      end
      default: begin
        ctx.pst = tnorm_pkg::PST_NONE;
        ctx = tnorm_pkg::f_plain(ctx, byte_r);
      end
    endcase
    if (last_r) begin
      // flush a held prefix, then return to the start of a text
      if (ctx.pst == tnorm_pkg::PST_E2) begin
        ctx = tnorm_pkg::f_word(ctx, tnorm_pkg::PFX_LEAD);
      end else if (ctx.pst == tnorm_pkg::PST_E280) begin
        ctx = tnorm_pkg::f_word(ctx, tnorm_pkg::PFX_LEAD);
        ctx = tnorm_pkg::f_word(ctx, tnorm_pkg::PFX_MID);
      end
      ctx.pst       = tnorm_pkg::PST_NONE;
      ctx.word_open = 1'b0;
      ctx.held      = 5'd0;
      ctx.emitted   = 1'b0;
      ctx.plan.marker = (ctx.plan.lead_cnt == 5'd0) && (ctx.plan.nw == 2'd0);
    end
  end

  assign has       = (ctx.plan.lead_cnt != 5'd0) || (ctx.plan.nw != 2'd0) || last_r;
  assign take      = in_full && (!has || emit_free);
  assign in_stall  = in_full && !take;
  assign accept    = in_valid && !in_stall;
  assign req.valid = in_full && has;
  assign req.plan  = ctx.plan;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full   <= 1'b0;
      pst       <= tnorm_pkg::PST_NONE;
      word_open <= 1'b0;
      held      <= 5'd0;
      emitted   <= 1'b0;
    end else begin
      in_full <= accept || (in_full && !take);
      if (take) begin
        pst       <= ctx.pst;
        word_open <= ctx.word_open;
        held      <= ctx.held;
        emitted   <= ctx.emitted;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

endmodule

// File: hw/rtl/tnorm_emit.sv
// Result sequencer: streams the bytes of one planned request, one per cycle while out_stall is low.
module tnorm_emit (
  input  logic            clk,
  input  logic            rst,
  input  tnorm_pkg::req_t req,
  output logic            emit_free,
  output logic            out_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            byte_present,
  output logic            text_end,
  output logic            run_end
);

  logic                                      busy;
  logic [7:0]                                lead_byte;
  logic [4:0]                                lead_cnt;
  logic [tnorm_pkg::WORD_SLOTS-1:0][7:0]     w;
  logic [1:0]                                nw;
  logic [1:0]                                wpos;
  logic                                      text_last;
  logic                                      marker;
  logic                                      cur_final;

  always_comb begin
    if (marker) begin
      cur_final = 1'b1;
      out_byte  = 8'h00;
    end else if (lead_cnt != 5'd0) begin
      cur_final = (lead_cnt == 5'd1) && (nw == 2'd0);
      out_byte  = lead_byte;
    end else begin
      cur_final = (wpos == nw - 2'd1);
      out_byte  = w[wpos];
    end
  end

  assign out_valid    = busy;
  assign byte_present = !marker;
  assign run_end      = cur_final;
  assign text_end     = cur_final && text_last;
  assign emit_free    = !busy || (cur_final && !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (emit_free) begin
      busy <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_free && req.valid) begin
      lead_byte <= req.plan.lead_byte;
      lead_cnt  <= req.plan.lead_cnt;
      w         <= req.plan.w;
      nw        <= req.plan.nw;
      wpos      <= 2'd0;
      text_last <= req.plan.text_last;
      marker    <= req.plan.marker;
    end else if (busy && !out_stall) begin
      if (lead_cnt != 5'd0) begin
        lead_cnt <= lead_cnt - 5'd1;
      end else begin
        wpos <= wpos + 2'd1;
      end
    end
  end

endmodule

// File: test/tb.sv
// Testbench of the transcript text normaliser: byte stream stimulus, predicted output, checking.
`timescale 1ns / 100ps

module tb;
  import tnorm_pkg::*;

  localparam int MAX_OUT = 20;

  typedef struct {
    logic [7:0] b;
    logic       present;
    logic       tend;
    logic       rend;
  } norm_res_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    logic       wait_idle;
  } raw_item_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       byte_present;
  logic       text_end;
  logic       run_end;

  raw_item_t  raw_text_q[$];
  norm_res_t  norm_want_q[$];
  norm_res_t  step_q[$];

  pst_t        pfx = PST_NONE;
  bit          in_word = 1'b0;
  int unsigned held_apos = 0;
  bit          any_word = 1'b0;

  int errors = 0;
  int burst_left = 8;
  int gap_left = 0;
  int stall_mode = 0;
  int stall_span = 0;
  int unsigned cyc = 0;

  transcript_text_normalizer dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_byte(in_byte),
    .in_last(in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte(out_byte),
    .byte_present(byte_present),
    .text_end(text_end),
    .run_end(run_end)
  );

  always #2 clk = ~clk;

  task automatic put_out(logic [7:0] b);
    if (step_q.size() < MAX_OUT) begin
      step_q.insert(step_q.size(), '{b, 1'b1, 1'b0, 1'b0});
    end
  endtask

  task automatic take_word(logic [7:0] b);
    if (!in_word) begin
      if (any_word) begin
        put_out(CH_SPACE);
      end
      in_word  = 1'b1;
      any_word = 1'b1;
    end else begin
      while (held_apos > 0) begin
        put_out(CH_APOS);
        held_apos--;
      end
    end
    held_apos = 0;
    put_out(b);
  endtask

  task automatic take_apos();
    if (in_word && held_apos < HELD_CAP) begin
      held_apos++;
    end
  endtask

  task automatic take_sep();
    in_word   = 1'b0;
    held_apos = 0;
  endtask

  task automatic classify_byte(logic [7:0] c);
    if (c == PFX_LEAD) begin
      pfx = PST_E2;
    end else if (c >= HIGH_BASE || (c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                 (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)) begin
      take_word(c);
    end else if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      take_word(c + CASE_STEP);
    end else if (c == CH_APOS) begin
      take_apos();
    end else begin
      take_sep();
    end
  endtask

  task automatic normalize_byte(logic [7:0] c, logic last);
    step_q.delete();
    case (pfx)
      PST_E2: begin
        if (c == PFX_MID) begin
          pfx = PST_E280;
        end else begin
          pfx = PST_NONE;
          take_word(PFX_LEAD);
          classify_byte(c);
        end
      end
      PST_E280: begin
        pfx = PST_NONE;
        if (c == QUOTE_L || c == QUOTE_R) begin
          take_apos();
        end else if (c == DASH_EN || c == DASH_EM || c == DQUOTE_L || c == DQUOTE_R ||
                     c == ELLIPSIS) begin
          take_sep();
        end else begin
          take_word(PFX_LEAD);
          take_word(PFX_MID);
          classify_byte(c);
        end
      end
      default: begin
        pfx = PST_NONE;
        classify_byte(c);
      end
    endcase
    if (last) begin
      if (pfx == PST_E2) begin
        take_word(PFX_LEAD);
      end else if (pfx == PST_E280) begin
        take_word(PFX_LEAD);
        take_word(PFX_MID);
      end
      pfx       = PST_NONE;
      in_word   = 1'b0;
      held_apos = 0;
      any_word  = 1'b0;
      if (step_q.size() == 0) begin
        step_q.insert(0, '{8'h00, 1'b0, 1'b1, 1'b0});
      end else begin
        step_q[step_q.size()-1].tend = 1'b1;
      end
    end
    if (step_q.size() > 0) begin
      step_q[step_q.size()-1].rend = 1'b1;
    end
    foreach (step_q[i]) begin
      norm_want_q.insert(norm_want_q.size(), step_q[i]);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  task automatic add_raw(logic [7:0] b, logic last, logic wait_idle = 1'b0);
    raw_text_q.insert(raw_text_q.size(), '{b, last, wait_idle});
  endtask

  task automatic gen_text(int n_tok, logic wait_idle);
    logic [7:0] tq[$];
    logic [7:0] c;
    int kind;
    int len;
    for (int k = 0; k < n_tok; k++) begin
      kind = $urandom_range(0, 99);
      if (kind < 40) begin
        len = $urandom_range(1, 6);
        for (int j = 0; j < len; j++) begin
          case ($urandom_range(0, 3))
            0: tq.insert(tq.size(), 8'(CH_LOWER_A + $urandom_range(0, 25)));
            1: tq.insert(tq.size(), 8'(CH_UPPER_A + $urandom_range(0, 25)));
            2: tq.insert(tq.size(), 8'(CH_DIGIT_0 + $urandom_range(0, 9)));
            default: tq.insert(tq.size(), 8'($urandom_range(128, 255)));
          endcase
        end
      end else if (kind < 55) begin
        if ($urandom_range(0, 4) == 0) begin
          len = $urandom_range(14, 20);
          repeat (len) tq.insert(tq.size(), CH_APOS);
        end else begin
          len = $urandom_range(1, 3);
          for (int j = 0; j < len; j++) begin
            if ($urandom_range(0, 2) == 0) begin
              tq.insert(tq.size(), PFX_LEAD);
              tq.insert(tq.size(), PFX_MID);
              tq.insert(tq.size(), $urandom_range(0, 1) ? QUOTE_R : QUOTE_L);
            end else begin
              tq.insert(tq.size(), CH_APOS);
            end
          end
        end
      end else if (kind < 75) begin
        if ($urandom_range(0, 1)) begin
          tq.insert(tq.size(), PFX_LEAD);
          tq.insert(tq.size(), PFX_MID);
          case ($urandom_range(0, 4))
            0: tq.insert(tq.size(), DASH_EN);
            1: tq.insert(tq.size(), DASH_EM);
            2: tq.insert(tq.size(), DQUOTE_L);
            3: tq.insert(tq.size(), DQUOTE_R);
            default: tq.insert(tq.size(), ELLIPSIS);
          endcase
        end else begin
          do begin
            c = 8'($urandom_range(0, 127));
          end while ((c >= CH_LOWER_A && c <= CH_LOWER_Z) ||
                     (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                     (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) || c == CH_APOS);
          tq.insert(tq.size(), c);
        end
      end else if (kind < 87) begin
        tq.insert(tq.size(), PFX_LEAD);
        if ($urandom_range(0, 1)) begin
          tq.insert(tq.size(), PFX_MID);
        end
        tq.insert(tq.size(), 8'($urandom_range(0, 255)));
      end else begin
        tq.insert(tq.size(), 8'($urandom_range(0, 255)));
      end
    end
    foreach (tq[i]) begin
      add_raw(tq[i], i == tq.size() - 1, (i == 0) ? wait_idle : 1'b0);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        normalize_byte(in_byte, in_last);
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (raw_text_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (raw_text_q[0].wait_idle && norm_want_q.size() != 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_byte  <= raw_text_q[0].b;
          in_last  <= raw_text_q[0].last;
          raw_text_q.pop_front();
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (stall_span <= 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_span = $urandom_range(50, 150);
    end
    stall_span--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= cyc[2];
    endcase
  end

  always @(posedge clk) begin
    norm_res_t w;
    if (!rst && out_valid && !out_stall) begin
      if (norm_want_q.size() == 0) begin
        report_mismatch("unexpected out_byte", out_byte, 0);
      end else begin
        w = norm_want_q.pop_front();
        if (byte_present !== w.present) report_mismatch("byte_present", byte_present, w.present);
        if (out_byte !== w.b) report_mismatch("out_byte", out_byte, w.b);
        if (text_end !== w.tend) report_mismatch("text_end", text_end, w.tend);
        if (run_end !== w.rend) report_mismatch("run_end", run_end, w.rend);
      end
    end
  end

  initial begin
    add_raw(CH_APOS, 1'b0);
    add_raw("A", 1'b0);
    add_raw(CH_APOS, 1'b0);
    add_raw(CH_APOS, 1'b0);
    add_raw("Z", 1'b0);
    add_raw(PFX_LEAD, 1'b0);
    add_raw(PFX_MID, 1'b0);
    add_raw(QUOTE_R, 1'b0);
    add_raw("9", 1'b0);
    add_raw(PFX_LEAD, 1'b0);
    add_raw(PFX_MID, 1'b0);
    add_raw(DASH_EM, 1'b0);
    add_raw("a", 1'b0);
    add_raw(8'h00, 1'b0);
    add_raw(PFX_LEAD, 1'b0);
    add_raw(PFX_LEAD, 1'b0);
    add_raw(PFX_MID, 1'b0);
    add_raw(QUOTE_L, 1'b0);
    add_raw("z", 1'b0);
    add_raw(PFX_LEAD, 1'b0);
    add_raw(PFX_MID, 1'b0);
    add_raw("0", 1'b0);
    add_raw(8'hFF, 1'b0);
    add_raw(8'h7F, 1'b0);
    add_raw(PFX_LEAD, 1'b1);
    add_raw(CH_SPACE, 1'b1);
    add_raw(PFX_LEAD, 1'b0);
    add_raw(PFX_MID, 1'b1);
    gen_text(6, 1'b1);
    for (int t = 1; raw_text_q.size() < 120; t++) begin
      gen_text($urandom_range(1, 12), t == 8);
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (raw_text_q.size() > 0 || in_valid || norm_want_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
